/* rtl/yuyv_stream_to_rgb_pixels_macros.svh */
// assertion macros shared by the yuyv to rgb design
`ifndef YUYV_STREAM_TO_RGB_PIXELS_MACROS_SVH
`define YUYV_STREAM_TO_RGB_PIXELS_MACROS_SVH

// same-cycle implication, disabled during reset
`define Y2R_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define Y2R_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/y2r_pkg.sv */
// shared types, constants and register codes for the yuyv to rgb converter
`timescale 1ns / 1ps

package y2r_pkg;

  // default size limits
  localparam int MAX_STRIDE_BYTES_DEF = 8192;
  localparam int MAX_ROWS_DEF         = 4096;

  // register widths and reset values
  localparam int PAIRS_W  = 12;
  localparam int STRIDE_W = 14;
  localparam int ROWS_W   = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  localparam logic [PAIRS_W-1:0]  PAIRS_RESET  = 12'd320;
  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 14'd1280;
  localparam logic [ROWS_W-1:0]   ROWS_RESET   = 13'd480;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PAIRS_PER_LINE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_STRIDE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_PER_FRAME = 2'd2;

  // q10 arithmetic, bt.601
  localparam int SUM_W   = 21;
  localparam int Q_SHIFT = 10;
  localparam logic signed [SUM_W-1:0] COEF_Y   = 21'sd1192;
  localparam logic signed [SUM_W-1:0] COEF_RV  = 21'sd1634;
  localparam logic signed [SUM_W-1:0] COEF_GV  = 21'sd833;
  localparam logic signed [SUM_W-1:0] COEF_GU  = 21'sd400;
  localparam logic signed [SUM_W-1:0] COEF_BU  = 21'sd2066;
  localparam logic signed [SUM_W-1:0] LUMA_OFFSET   = 21'sd16;
  localparam logic signed [SUM_W-1:0] CHROMA_OFFSET = 21'sd128;

  // one pixel pair waiting for conversion
  typedef struct packed {
    logic [7:0] y0;
    logic [7:0] y1;
    logic [7:0] cb;
    logic [7:0] cr;
    logic       line_end;
    logic       frame_end;
  } pair_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

endpackage

/* rtl/yuyv_stream_to_rgb_pixels.sv */
// top level: yuyv camera byte stream to rgb888 pixel stream
// usage:
//   byte channel (byte_valid / byte_stall / pixel_byte) takes one raw buffer
//   byte per transaction, Y0 Cb Y1 Cr order, line by line including padding
//   pixel channel (pixel_valid / pixel_stall) gives one rgb pixel per
//   transaction with pair_last, line_end and frame_end flags
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes the
//   line and frame geometry; cfg_ready is always high, write only when idle
// throughput: one byte per cycle unless byte_stall holds; every Cr byte in the
//   active part of a line yields two pixels, which leave one at a time through
//   the shared color converter, so four bytes per pair keep it busy half time
// path: each pixel of a pair moves from its Cr byte transaction through the
//   pair slot, then the output register; the second pixel follows the first
// stall: while pixel_stall holds, the pair slot waits and padding, luma and
//   Cb bytes are still taken; only a Cr byte that finds the pair slot full
//   is stalled
// reset (rst, synchronous): geometry returns to 320 pairs, 1280 byte stride,
//   480 rows; column and row counters and all valid flags clear
`timescale 1ns / 1ps
`include "yuyv_stream_to_rgb_pixels_macros.svh"

module yuyv_stream_to_rgb_pixels #(
  parameter int MAX_STRIDE_BYTES = y2r_pkg::MAX_STRIDE_BYTES_DEF,
  parameter int MAX_ROWS         = y2r_pkg::MAX_ROWS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // byte stream in
  input  logic                            byte_valid,
  output logic                            byte_stall,
  input  logic [7:0]                      pixel_byte,
  // pixel stream out
  output logic                            pixel_valid,
  input  logic                            pixel_stall,
  output logic [7:0]                      red,
  output logic [7:0]                      green,
  output logic [7:0]                      blue,
  output logic                            pair_last,
  output logic                            line_end,
  output logic                            frame_end,
  // register writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [y2r_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [y2r_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // widths that follow from the limits
  localparam int SW   = $clog2(MAX_STRIDE_BYTES + 1);
  localparam int CLW  = $clog2(MAX_STRIDE_BYTES);
  localparam int CW   = (SW > y2r_pkg::STRIDE_W) ? SW : y2r_pkg::STRIDE_W;
  localparam int RSW  = $clog2(MAX_ROWS + 1);
  localparam int ROWW = $clog2(MAX_ROWS);
  localparam int RCW  = (RSW > y2r_pkg::ROWS_W) ? RSW : y2r_pkg::ROWS_W;

  // configuration registers
  logic [y2r_pkg::PAIRS_W-1:0]  pairs_per_line;
  logic [y2r_pkg::STRIDE_W-1:0] line_stride;
  logic [y2r_pkg::ROWS_W-1:0]   rows_per_frame;

  // position and pair capture
  logic [CLW-1:0]  byte_column;
  logic [ROWW-1:0] row_count;
  logic [7:0]      first_luma_hold;
  logic [7:0]      blue_chroma_hold;
  logic [7:0]      second_luma_hold;

  // pair slot feeding the converter
  y2r_pkg::pair_t  pend;
  logic            pend_valid;
  logic            phase;

  // derived geometry
  logic [CW-1:0]   stride_wide;
  logic [CW-1:0]   stride_eff;
  logic [CW-1:0]   fit;
  logic [CW-1:0]   pairs_wide;
  logic [CW-1:0]   eff_pairs;
  logic [CW-1:0]   col_wide;
  logic [CW-1:0]   col_inc;
  logic [CW-1:0]   pair_idx;
  logic [RCW-1:0]  rows_wide;
  logic [RCW-1:0]  rows_eff;
  logic [RCW-1:0]  row_inc;
  logic            line_done;
  logic            last_row;
  logic            in_range;
  logic            pair_line_end;
  logic            cr_next;
  logic            byte_take;
  logic            out_move;
  logic [7:0]      conv_luma;
  y2r_pkg::rgb_t   conv_pixel;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pairs_per_line <= y2r_pkg::PAIRS_RESET;
      line_stride    <= y2r_pkg::STRIDE_RESET;
      rows_per_frame <= y2r_pkg::ROWS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        y2r_pkg::REG_PAIRS_PER_LINE: pairs_per_line <= cfg_data[y2r_pkg::PAIRS_W-1:0];
        y2r_pkg::REG_LINE_STRIDE:    line_stride    <= cfg_data[y2r_pkg::STRIDE_W-1:0];
        y2r_pkg::REG_ROWS_PER_FRAME: rows_per_frame <= cfg_data[y2r_pkg::ROWS_W-1:0];
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // stride saturates at the limit, zero acts as one
  assign stride_wide = CW'(line_stride);
  always_comb begin
    if (stride_wide > CW'(MAX_STRIDE_BYTES)) begin
      stride_eff = CW'(MAX_STRIDE_BYTES);
    end else if (stride_wide == '0) begin
      stride_eff = CW'(1);
    end else begin
      stride_eff = stride_wide;
    end
  end

  // same treatment for the row count
  assign rows_wide = RCW'(rows_per_frame);
  always_comb begin
    if (rows_wide > RCW'(MAX_ROWS)) begin
      rows_eff = RCW'(MAX_ROWS);
    end else if (rows_wide == '0) begin
      rows_eff = RCW'(1);
    end else begin
      rows_eff = rows_wide;
    end
  end

  // only whole pairs that fit in the stride carry pixels
  assign fit        = stride_eff >> 2;
  assign pairs_wide = CW'(pairs_per_line);
  assign eff_pairs  = (pairs_wide < fit) ? pairs_wide : fit;

  assign col_wide      = CW'(byte_column);
  assign col_inc       = col_wide + CW'(1);
  assign pair_idx      = col_wide >> 2;
  assign line_done     = (col_inc >= stride_eff);
  assign in_range      = (pair_idx < eff_pairs);
  assign pair_line_end = ((pair_idx + CW'(1)) == eff_pairs);

  assign row_inc  = RCW'(row_count) + RCW'(1);
  assign last_row = (row_inc >= rows_eff);

  // a Cr byte needs the pair slot; everything else always goes through
  assign cr_next    = in_range && (byte_column[1:0] == 2'd3);
  assign byte_stall = pend_valid && cr_next;
  assign byte_take  = byte_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_column      <= '0;
      row_count        <= '0;
      first_luma_hold  <= '0;
      blue_chroma_hold <= '0;
      second_luma_hold <= '0;
    end else if (byte_take) begin
      if (in_range) begin
        case (byte_column[1:0])
          2'd0:    first_luma_hold  <= pixel_byte;
          2'd1:    blue_chroma_hold <= pixel_byte;
          2'd2:    second_luma_hold <= pixel_byte;
          default: ;  // Cr goes straight into the pair slot
        endcase
      end
      if (line_done) begin
        byte_column <= '0;
        row_count   <= last_row ? '0 : row_inc[ROWW-1:0];
      end else begin
        byte_column <= col_inc[CLW-1:0];
      end
    end
  end

  // output register moves when empty or when its pixel is taken
  assign out_move  = !pixel_valid || !pixel_stall;
  assign conv_luma = phase ? pend.y1 : pend.y0;

  y2r_convert u_convert (
    .luma  (conv_luma),
    .cb    (pend.cb),
    .cr    (pend.cr),
    .pixel (conv_pixel)
  );

  // pair slot: loaded on a Cr byte, drained one pixel per move
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      phase      <= 1'b0;
    end else begin
      if (pend_valid && out_move) begin
        phase <= !phase;
        if (phase) begin
          pend_valid <= 1'b0;
        end
      end
      if (byte_take && cr_next) begin
        pend_valid <= 1'b1;
        phase      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_take && cr_next) begin
      pend.y0        <= first_luma_hold;
      pend.y1        <= second_luma_hold;
      pend.cb        <= blue_chroma_hold;
      pend.cr        <= pixel_byte;
      pend.line_end  <= pair_line_end;
      pend.frame_end <= pair_line_end && last_row;
    end
  end

  // pixel output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (out_move) begin
      pixel_valid <= pend_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_valid && out_move) begin
      red       <= conv_pixel.red;
      green     <= conv_pixel.green;
      blue      <= conv_pixel.blue;
      pair_last <= phase;
      line_end  <= phase && pend.line_end;
      frame_end <= phase && pend.frame_end;
    end
  end

  // checks on the pair slot and flag coding
  `Y2R_ASSERT_IMPLY(a_stall_needs_slot, clk, rst, byte_stall, pend_valid,
                    "byte stalled with the pair slot empty")
  `Y2R_ASSERT_NEXT(a_cr_loads_slot, clk, rst, byte_take && cr_next,
                   pend_valid && !phase, "Cr byte did not load the pair slot")
  `Y2R_ASSERT_NEXT(a_second_frees_slot, clk, rst, pend_valid && phase && out_move,
                   !pend_valid, "pair slot still full after its second pixel")
  `Y2R_ASSERT_IMPLY(a_flags_on_second, clk, rst, pixel_valid && !pair_last,
                    !line_end && !frame_end, "end flag on the first pixel of a pair")
  `Y2R_ASSERT_IMPLY(a_frame_in_line, clk, rst, pixel_valid && frame_end, line_end,
                    "frame end without line end")

endmodule

/* rtl/y2r_convert.sv */
// ycbcr to rgb color conversion with q10 coefficients and clamping
`timescale 1ns / 1ps

module y2r_convert (
  input  logic [7:0]      luma,
  input  logic [7:0]      cb,
  input  logic [7:0]      cr,
  output y2r_pkg::rgb_t   pixel
);

  localparam int SUM_W = y2r_pkg::SUM_W;
  localparam int QS    = y2r_pkg::Q_SHIFT;

  logic signed [SUM_W-1:0] y;
  logic signed [SUM_W-1:0] u;
  logic signed [SUM_W-1:0] v;
  logic signed [SUM_W-1:0] y_term;
  logic signed [SUM_W-1:0] r_sum;
  logic signed [SUM_W-1:0] g_sum;
  logic signed [SUM_W-1:0] b_sum;

  // floor shift then saturate to 0..255
  function automatic logic [7:0] clamp_q10(input logic signed [SUM_W-1:0] s);
    logic [7:0] res;
    if (s[SUM_W-1]) begin
      res = 8'h00;
    end else if (|s[SUM_W-2:QS+8]) begin
      res = 8'hFF;
    end else begin
      res = s[QS+7:QS];
    end
    return res;
  endfunction

  assign y = $signed({{(SUM_W-8){1'b0}}, luma}) - y2r_pkg::LUMA_OFFSET;
  assign u = $signed({{(SUM_W-8){1'b0}}, cb}) - y2r_pkg::CHROMA_OFFSET;
  assign v = $signed({{(SUM_W-8){1'b0}}, cr}) - y2r_pkg::CHROMA_OFFSET;

  assign y_term = y2r_pkg::COEF_Y * y;
  assign r_sum  = y_term + y2r_pkg::COEF_RV * v;
  assign g_sum  = y_term - y2r_pkg::COEF_GV * v - y2r_pkg::COEF_GU * u;
  assign b_sum  = y_term + y2r_pkg::COEF_BU * u;

  assign pixel.red   = clamp_q10(r_sum);
  assign pixel.green = clamp_q10(g_sum);
  assign pixel.blue  = clamp_q10(b_sum);

endmodule
